// ===== design/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the timed duplicate filter: field widths,
// slot word layout, opcodes, controller states and register map.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int TDF_TABLE_SLOTS = 64;

  localparam int SRC_W  = 15;
  localparam int KEY_W  = 32;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 8;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd2;

  // APB map: one 32-bit register per word.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW = '0;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_RECORD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [SRC_W-1:0]  src;
    logic [KEY_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
  } slot_word_t;

endpackage

// ===== design/tdf_start_slot.sv =====
// ----------------------------------------------------------------------------
// tdf_start_slot
// Key mod TABLE_SLOTS by reciprocal multiplication, then remainder by multiply-back.
// ----------------------------------------------------------------------------
module tdf_start_slot #(
  parameter int TABLE_SLOTS = tdf_pkg::TDF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tdf_pkg::KEY_W-1:0]      key,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot
);
  import tdf_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int SHIFT   = KEY_W + IDX_W;
  // ceil(2^SHIFT / TABLE_SLOTS): exact quotient for every KEY_W-bit key
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_WIDE[RECIP_W-1:0];
  localparam logic [IDX_W-1:0]   SLOTS_LO = IDX_W'(TABLE_SLOTS);

  logic [KEY_W-1:0]   key_q;
  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   quot_lo;
  logic [IDX_W-1:0]   key_lo;
  logic [2*IDX_W-1:0] back;
  logic [IDX_W-1:0]   rem;
  logic               stage1;
  logic               stage2;

  // Quotient from the reciprocal; the remainder only needs its low bits.
  assign prod = key_q * RECIP;
  assign back = quot_lo * SLOTS_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    if (stage1) begin
      quot_lo <= prod[SHIFT +: IDX_W];
      key_lo  <= key_q[IDX_W-1:0];
    end
    if (stage2) begin
      rem <= key_lo - back[IDX_W-1:0];
    end
  end

  assign slot = rem;

endmodule

// ===== design/timed_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// timed_duplicate_filter
// Hash table of recently seen (source, sequence) pairs with an age window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per request: opcode
//   selects check (is the pair stored and younger than window_seconds?) or
//   record (write pair and now_seconds into the first free or expired slot).
//   Output channel (out_valid/out_ready) returns one beat per request with
//   is_repeat, stored and no_room; fields that do not apply read zero.
//   APB register 0 (byte address 0) holds window_seconds, reset value 2.
//   The key is first reduced to a start slot (reciprocal multiply, then
//   remainder), then the slots along the path are read in turn through the
//   registered memory port and evaluated, then the output register is
//   loaded. A new beat is taken only after the previous result has entered
//   the output register, one item in flight at a time. The length of the
//   probe walk through the single-port-read slot memory sets how long a
//   request takes.
//   Reset: a clearing pass writes every slot invalid, one slot per cycle;
//   in_ready stays low until it ends. APB writes are taken throughout.
//   Stall: a finished result waits in the output register; the next beat is
//   accepted meanwhile, and its own result holds until the register frees.
// ----------------------------------------------------------------------------
module timed_duplicate_filter #(
  parameter int TABLE_SLOTS = tdf_pkg::TDF_TABLE_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdf_pkg::PADDR_W-1:0]   paddr,
  input  logic [tdf_pkg::PDATA_W-1:0]   pwdata,
  output logic [tdf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [tdf_pkg::SRC_W-1:0]     source_address,
  input  logic [tdf_pkg::KEY_W-1:0]     sequence_number,
  input  logic [tdf_pkg::TIME_W-1:0]    now_seconds,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_repeat,
  output logic                          stored,
  output logic                          no_room
);
  import tdf_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] ALL_CNT  = CNT_W'(TABLE_SLOTS);

  state_t state;
  state_t state_next;

  // configuration register
  logic [WIN_W-1:0]     window;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_we;

  // captured request
  op_t               op;
  logic [SRC_W-1:0]  src;
  logic [KEY_W-1:0]  seq;
  logic [TIME_W-1:0] now;

  // start-slot unit
  logic             hash_start;
  logic             hash_done;
  logic [IDX_W-1:0] hash_slot;

  // slot memory
  slot_word_t       mem [TABLE_SLOTS];
  slot_word_t       rd_data;
  slot_word_t       mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;
  logic             rd_en;

  // probe walk
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] issue_idx;
  logic [CNT_W-1:0] issue_cnt;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             last_eval;
  logic [TIME_W-1:0] age;
  logic             live;
  logic             match;
  logic             probe_stop;
  logic             free_slot;

  // pending result and output register
  logic res_repeat;
  logic res_stored;
  logic res_full;
  logic out_load;

  // --------------------------------------------------------------------------
  // APB: always ready, write at the access phase
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_WINDOW) begin
      prdata = PDATA_W'(window);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we && reg_idx == REG_WINDOW) begin
      window <= pwdata[WIN_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Start slot: (source XOR sequence) mod TABLE_SLOTS
  // --------------------------------------------------------------------------
  tdf_start_slot #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_start_slot (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .key  (KEY_W'(source_address) ^ sequence_number),
    .done (hash_done),
    .slot (hash_slot)
  );

  // --------------------------------------------------------------------------
  // Slot evaluation on the word that just came back from memory
  // --------------------------------------------------------------------------
  assign age       = now - rd_data.stamp;
  assign live      = age < TIME_W'(window);
  assign match     = (rd_data.src == src) && (rd_data.seq == seq);
  assign free_slot = !rd_data.valid || !live;
  // the final slot of the path is evaluated once every read has been issued
  assign last_eval = (issue_cnt == ALL_CNT);

  always_comb begin
    probe_stop = 1'b0;
    if (state == ST_PROBE && pend) begin
      unique case (op)
        OP_CHECK:  probe_stop = !rd_data.valid || (match && live) || last_eval;
        OP_RECORD: probe_stop = free_slot || last_eval;
        default:   probe_stop = 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Controller: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_HASH;
      ST_HASH:   if (hash_done) state_next = ST_PROBE;
      ST_PROBE:  if (probe_stop) state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready   = 1'b0;
    hash_start = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_idx;
    mem_wdata  = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        // sweep: write every slot invalid
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        hash_start = in_valid;
      end
      ST_HASH: begin
      end
      ST_PROBE: begin
        // keep one read in flight ahead of the evaluation
        rd_en = (issue_cnt != ALL_CNT);
        if (pend && op == OP_RECORD && free_slot) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx;
          mem_wdata = '{valid: 1'b1, src: src, seq: seq, stamp: now};
        end
      end
      ST_RESULT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Slot memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[issue_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_HASH) begin
        pend <= 1'b0;
      end else if (state == ST_PROBE) begin
        pend <= rd_en;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // capture the request beat
    if (in_valid && in_ready) begin
      op  <= op_t'(opcode);
      src <= source_address;
      seq <= sequence_number;
      now <= now_seconds;
    end
    // start the walk at the reduced slot
    if (state == ST_HASH && hash_done) begin
      issue_idx <= hash_slot;
      issue_cnt <= '0;
    end else if (rd_en) begin
      issue_idx <= (issue_idx == LAST_IDX) ? '0 : issue_idx + 1'b1;
      issue_cnt <= issue_cnt + 1'b1;
    end
    if (rd_en) begin
      pend_idx <= issue_idx;
    end
    // hold the outcome of the walk until the output register frees
    if (probe_stop) begin
      res_repeat <= (op == OP_CHECK) && rd_data.valid && match && live;
      res_stored <= (op == OP_RECORD) && free_slot;
      res_full   <= (op == OP_RECORD) && !free_slot;
    end
    if (out_load) begin
      is_repeat <= res_repeat;
      stored    <= res_stored;
      no_room   <= res_full;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_PROBE))
    else $error("slot memory written outside clear or probe");

  a_check_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && op == OP_CHECK) |-> !mem_we)
    else $error("check request wrote the slot memory");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request accepted during clearing pass");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({is_repeat, stored, no_room}))
    else $error("more than one result flag set");

  a_stop_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && pend && last_eval) |-> probe_stop)
    else $error("probe walk ran past the last slot");

endmodule
